[hw/rtl/brb_pkg.sv]
// shared types and constants of the byte ring buffer with peek
`default_nettype none
package brb_pkg;

  localparam int unsigned DEPTH_DEFAULT = 1024;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned CNT_W         = 11;
  localparam int unsigned KIND_W        = 3;
  localparam int unsigned S_TDATA_W     = 24;
  localparam int unsigned M_TDATA_W     = 48;
  localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

  typedef enum logic [KIND_W-1:0] {
    OP_WRITE   = 3'd0,
    OP_READ    = 3'd1,
    OP_PEEK    = 3'd2,
    OP_DISCARD = 3'd3,
    OP_REWIND  = 3'd4,
    OP_CLEAR   = 3'd5
  } op_kind_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic take;  // beat accepted: latch operation, start store read
    logic exec;  // apply operation and load result register
  } brb_cmd_t;

  typedef struct packed {
    logic out_free;  // result register empty or being drained
  } brb_stat_t;

endpackage
`default_nettype wire

[hw/rtl/brb_ram.sv]
// generic single write port ram with registered read
`default_nettype none
module brb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/brb_ctrl.sv]
// operation sequencer of the byte ring buffer
`default_nettype none
module brb_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_tvalid_i,
  output logic                   s_tready_o,
  input  wire brb_pkg::brb_stat_t stat_i,
  output brb_pkg::brb_cmd_t      cmd_o
);
  import brb_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    s_tready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // store data is valid now; wait for room in the result register
        if (stat_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/brb_dp.sv]
// pointers, counts, byte store and result register of the ring buffer
`default_nettype none
module brb_dp #(
  parameter int unsigned DEPTH = brb_pkg::DEPTH_DEFAULT
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire brb_pkg::brb_cmd_t             cmd_i,
  output brb_pkg::brb_stat_t                 stat_o,
  input  wire logic [brb_pkg::KIND_W-1:0]    s_tuser_i,
  input  wire logic [brb_pkg::S_TDATA_W-1:0] s_tdata_i,
  output logic                               m_tvalid_o,
  input  wire logic                          m_tready_i,
  output logic      [brb_pkg::M_TDATA_W-1:0] m_tdata_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [brb_pkg::CNT_W-1:0]     cfg_wdata_i
);
  import brb_pkg::*;

  localparam int unsigned PW      = $clog2(DEPTH);
  localparam int unsigned SW      = ((PW > CNT_W) ? PW : CNT_W) + 1;
  localparam int unsigned CAP_MAX = (DEPTH > 2047) ? 2047 : DEPTH;
  localparam logic [CNT_W-1:0] CAP_LIMIT = CNT_W'(CAP_MAX);

  function automatic logic [PW-1:0] advance(input logic [PW-1:0]    p,
                                            input logic [CNT_W-1:0] n,
                                            input logic [CNT_W-1:0] cap);
    logic [SW-1:0] s;
    s = SW'(p) + SW'(n);
    if (s >= SW'(cap)) begin
      s = s - SW'(cap);
    end
    return PW'(s);
  endfunction

  logic [PW-1:0]     rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d, pk_ptr_q, pk_ptr_d;
  logic [CNT_W-1:0]  stored_q, stored_d, pkcnt_q, pkcnt_d, cap_q;
  op_kind_e          kind_q;
  logic [BYTE_W-1:0] byte_q;
  logic [CNT_W-1:0]  count_q;
  logic              m_valid_q;
  logic [BYTE_W-1:0] ob_q, ob_d;
  logic [CNT_W-1:0]  done_q, done_d, fill_q, peekl_q;

  logic [CNT_W-1:0]  cap_eff, drop_raw, drop_n;
  logic              ram_we;
  logic [BYTE_W-1:0] ram_q;
  logic [PW-1:0]     ram_raddr;

  // zero acts as one, anything above the store size as the store size
  assign cap_eff = (cap_q == '0) ? CNT_W'(1) : ((cap_q > CAP_LIMIT) ? CAP_LIMIT : cap_q);

  assign ram_raddr = (op_kind_e'(s_tuser_i) == OP_PEEK) ? pk_ptr_q : rd_ptr_q;

  brb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (byte_q),
    .re_i    (cmd_i.take),
    .raddr_i (ram_raddr),
    .rdata_o (ram_q)
  );

  assign drop_raw = (kind_q == OP_CLEAR) ? stored_q : count_q;
  assign drop_n   = (drop_raw > stored_q) ? stored_q : drop_raw;

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    pk_ptr_d = pk_ptr_q;
    stored_d = stored_q;
    pkcnt_d  = pkcnt_q;
    ob_d     = '0;
    done_d   = '0;
    ram_we   = 1'b0;
    unique case (kind_q)
      OP_WRITE: begin
        if (stored_q < cap_eff) begin
          ram_we   = cmd_i.exec;
          wr_ptr_d = advance(wr_ptr_q, CNT_W'(1), cap_eff);
          stored_d = stored_q + CNT_W'(1);
          pkcnt_d  = pkcnt_q + CNT_W'(1);
          done_d   = CNT_W'(1);
        end
      end
      OP_READ: begin
        if (stored_q != '0) begin
          ob_d     = ram_q;
          rd_ptr_d = advance(rd_ptr_q, CNT_W'(1), cap_eff);
          pk_ptr_d = rd_ptr_d;
          stored_d = stored_q - CNT_W'(1);
          pkcnt_d  = stored_d;
          done_d   = CNT_W'(1);
        end
      end
      OP_PEEK: begin
        if (pkcnt_q != '0) begin
          ob_d     = ram_q;
          pk_ptr_d = advance(pk_ptr_q, CNT_W'(1), cap_eff);
          pkcnt_d  = pkcnt_q - CNT_W'(1);
          done_d   = CNT_W'(1);
        end
      end
      OP_DISCARD, OP_CLEAR: begin
        if (drop_n != '0) begin
          rd_ptr_d = advance(rd_ptr_q, drop_n, cap_eff);
          pk_ptr_d = rd_ptr_d;
          stored_d = stored_q - drop_n;
          pkcnt_d  = stored_d;
          done_d   = drop_n;
        end
      end
      OP_REWIND: begin
        pk_ptr_d = rd_ptr_q;
        pkcnt_d  = stored_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q  <= '0;
      wr_ptr_q  <= '0;
      pk_ptr_q  <= '0;
      stored_q  <= '0;
      pkcnt_q   <= '0;
      cap_q     <= CAP_RESET;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q    <= cfg_wdata_i;
        rd_ptr_q <= '0;
        wr_ptr_q <= '0;
        pk_ptr_q <= '0;
        stored_q <= '0;
        pkcnt_q  <= '0;
      end else if (cmd_i.exec) begin
        rd_ptr_q <= rd_ptr_d;
        wr_ptr_q <= wr_ptr_d;
        pk_ptr_q <= pk_ptr_d;
        stored_q <= stored_d;
        pkcnt_q  <= pkcnt_d;
      end
      if (cmd_i.exec) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      kind_q  <= op_kind_e'(s_tuser_i);
      byte_q  <= s_tdata_i[BYTE_W-1:0];
      count_q <= s_tdata_i[BYTE_W+CNT_W-1:BYTE_W];
    end
    if (cmd_i.exec) begin
      ob_q    <= ob_d;
      done_q  <= done_d;
      fill_q  <= stored_d;
      peekl_q <= pkcnt_d;
    end
  end

  assign stat_o.out_free = !m_valid_q || m_tready_i;
  assign m_tvalid_o      = m_valid_q;
  assign m_tdata_o       = {(M_TDATA_W - BYTE_W - 3*CNT_W)'(0), peekl_q, fill_q, done_q, ob_q};

endmodule
`default_nettype wire

[hw/rtl/byte_ring_buffer_with_peek.sv]
// top level of the byte ring buffer with peek cursor
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  tuser: kind[2:0]; tdata: in_byte, count
//  m_       out  m_tvalid/m_tready  tdata: out_byte, done_count, fill_level, peek_left
//  cfg_     in   cfg_we             cfg_wdata: capacity
//
// each operation has an accept step, which starts the byte store read, and an
// execute step, which applies the pointer update and loads the result register.
// a result waiting in the result register does not block the next accept, but
// the execute step holds until that register is free.
// reset empties the buffer and sets capacity to 1024; no clearing pass, store
// contents are undefined until written. a capacity write also empties the buffer.
`default_nettype none
module byte_ring_buffer_with_peek #(
  parameter int unsigned DEPTH = brb_pkg::DEPTH_DEFAULT
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_tvalid_i,
  output logic                               s_tready_o,
  input  wire logic [brb_pkg::S_TDATA_W-1:0] s_tdata_i,  // in_byte[7:0], count[18:8]
  input  wire logic [brb_pkg::KIND_W-1:0]    s_tuser_i,  // kind[2:0]
  output logic                               m_tvalid_o,
  input  wire logic                          m_tready_i,
  // out_byte[7:0], done_count[18:8], fill_level[29:19], peek_left[40:30]
  output logic      [brb_pkg::M_TDATA_W-1:0] m_tdata_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [brb_pkg::CNT_W-1:0]     cfg_wdata_i
);
  import brb_pkg::*;

  brb_cmd_t  cmd;
  brb_stat_t stat;

  brb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  brb_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .s_tuser_i   (s_tuser_i),
    .s_tdata_i   (s_tdata_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

endmodule
`default_nettype wire

[hw/rtl/brb_checker.sv]
// port level checks of the byte ring buffer, bound to the top level
`default_nettype none
module brb_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_tvalid_i,
  input wire logic                          s_tready_i,
  input wire logic                          m_tvalid_i,
  input wire logic                          m_tready_i,
  input wire logic [brb_pkg::M_TDATA_W-1:0] m_tdata_i
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i))
    else $error("result beat changed while stalled");

  // one operation in flight: busy in the cycle after an accept
  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_i |=> !s_tready_i)
    else $error("input accepted while an operation was in flight");

  // a new result only comes out of the execute cycle
  a_res_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_i) |-> !$past(s_tready_i))
    else $error("result appeared without an execute cycle");

  // peek count never exceeds fill level
  a_peek_le_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> m_tdata_i[40:30] <= m_tdata_i[29:19])
    else $error("peek_left above fill_level");

  // a returned byte comes from a single byte read or peek
  a_byte_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tdata_i[7:0] != 8'd0 |-> m_tdata_i[18:8] == 11'd1)
    else $error("byte returned without a single byte done");

endmodule

bind byte_ring_buffer_with_peek brb_checker u_brb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_tvalid_i),
  .s_tready_i (s_tready_o),
  .m_tvalid_i (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_i  (m_tdata_o)
);
`default_nettype wire

[sim/byte_ring_buffer_with_peek_test.sv]
// testbench for the byte ring buffer with peek: random and directed operations
`timescale 1ns / 1ps
module byte_ring_buffer_with_peek_test;
  import brb_pkg::*;

  localparam int unsigned DEPTH          = DEPTH_DEFAULT;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam logic [KIND_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [KIND_W-1:0] OP_SPARE7 = 3'd7;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [CNT_W-1:0]  done_count;
    logic [CNT_W-1:0]  fill_level;
    logic [CNT_W-1:0]  peek_left;
  } buf_result_t;

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 s_tvalid_i  = 1'b0;
  logic                 s_tready_o;
  logic [S_TDATA_W-1:0] s_tdata_i   = '0;  // in_byte[7:0], count[18:8]
  logic [KIND_W-1:0]    s_tuser_i   = '0;  // kind[2:0]
  logic                 m_tvalid_o;
  logic                 m_tready_i  = 1'b0;
  // out_byte[7:0], done_count[18:8], fill_level[29:19], peek_left[40:30]
  logic [M_TDATA_W-1:0] m_tdata_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CNT_W-1:0]     cfg_wdata_i = '0;

  // buffer model
  logic [BYTE_W-1:0] store_model [DEPTH];
  int unsigned       rd_ptr, wr_ptr, pk_ptr, fill_cnt, peek_cnt;
  logic [CNT_W-1:0]  cap_reg = CAP_RESET;

  buf_result_t pending_results [$];
  int          beats_in, beats_out, err_cnt;
  int          tx_idle_pct, rx_idle_pct, rx_stall_left;
  int unsigned quiet_cycles;

  byte_ring_buffer_with_peek dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned live_cap();
    int unsigned c;
    c = cap_reg;
    if (c == 0) c = 1;
    if (c > DEPTH) c = DEPTH;
    return c;
  endfunction

  function automatic int unsigned step_ptr(int unsigned p, int unsigned n, int unsigned c);
    int unsigned s;
    s = p + n;
    if (s >= c) s = s - c;
    return s;
  endfunction

  function automatic void empty_buffer();
    rd_ptr   = 0;
    wr_ptr   = 0;
    pk_ptr   = 0;
    fill_cnt = 0;
    peek_cnt = 0;
  endfunction

  // pop up to n bytes from the front; peek cursor snaps back to the read side
  function automatic int unsigned drop_front(int unsigned n, int unsigned c);
    if (n == 0 || fill_cnt == 0) return 0;
    if (n > fill_cnt) n = fill_cnt;
    rd_ptr   = step_ptr(rd_ptr, n, c);
    pk_ptr   = rd_ptr;
    fill_cnt = fill_cnt - n;
    peek_cnt = fill_cnt;
    return n;
  endfunction

  function automatic buf_result_t predict_result(logic [KIND_W-1:0] kind,
                                                 logic [BYTE_W-1:0] din,
                                                 logic [CNT_W-1:0] n);
    buf_result_t r;
    int unsigned c;
    int unsigned done;
    c      = live_cap();
    done   = 0;
    r      = '0;
    case (kind)
      OP_WRITE: begin
        if (fill_cnt < c) begin
          store_model[wr_ptr] = din;
          wr_ptr   = step_ptr(wr_ptr, 1, c);
          fill_cnt = fill_cnt + 1;
          peek_cnt = peek_cnt + 1;
          done     = 1;
        end
      end
      OP_READ: begin
        if (fill_cnt > 0) begin
          r.out_byte = store_model[rd_ptr];
          rd_ptr   = step_ptr(rd_ptr, 1, c);
          pk_ptr   = rd_ptr;
          fill_cnt = fill_cnt - 1;
          peek_cnt = fill_cnt;
          done     = 1;
        end
      end
      OP_PEEK: begin
        if (peek_cnt > 0) begin
          r.out_byte = store_model[pk_ptr];
          pk_ptr   = step_ptr(pk_ptr, 1, c);
          peek_cnt = peek_cnt - 1;
          done     = 1;
        end
      end
      OP_DISCARD: done = drop_front(n, c);
      OP_REWIND: begin
        pk_ptr   = rd_ptr;
        peek_cnt = fill_cnt;
      end
      OP_CLEAR: done = drop_front(fill_cnt, c);
      default: ;
    endcase
    r.done_count = done[CNT_W-1:0];
    r.fill_level = fill_cnt[CNT_W-1:0];
    r.peek_left  = peek_cnt[CNT_W-1:0];
    return r;
  endfunction

  task automatic note_error(string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("%s", msg);
  endtask

  // predict on every accepted input beat, check every accepted output beat
  always @(posedge clk_i) begin : monitor
    buf_result_t got;
    buf_result_t want;
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_o) begin
        pending_results.push_back(predict_result(s_tuser_i, s_tdata_i[7:0], s_tdata_i[18:8]));
        beats_in++;
      end
      if (m_tvalid_o && m_tready_i) begin
        got = {m_tdata_o[7:0], m_tdata_o[18:8], m_tdata_o[29:19], m_tdata_o[40:30]};
        if (pending_results.size() == 0) begin
          note_error($sformatf("unexpected result %0d: byte %h done %0d fill %0d peek %0d",
                               beats_out, got.out_byte, got.done_count, got.fill_level,
                               got.peek_left));
        end else begin
          want = pending_results.pop_front();
          if (got.out_byte !== want.out_byte || got.done_count !== want.done_count ||
              got.fill_level !== want.fill_level || got.peek_left !== want.peek_left) begin
            note_error($sformatf(
              "result %0d: exp byte %h done %0d fill %0d peek %0d, got byte %h done %0d fill %0d peek %0d",
              beats_out, want.out_byte, want.done_count, want.fill_level, want.peek_left,
              got.out_byte, got.done_count, got.fill_level, got.peek_left));
          end
        end
        beats_out++;
      end
    end
  end

  // result side: random stalls, or one long hold-off when requested
  always @(posedge clk_i) begin
    if (rx_stall_left > 0) begin
      m_tready_i <= 1'b0;
      rx_stall_left--;
    end else begin
      m_tready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_op(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] din, logic [CNT_W-1:0] n);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= kind;
    s_tdata_i  <= {5'b0, n, din};
    do @(posedge clk_i); while (!s_tready_o);
  endtask

  // stop sending and wait until every predicted result has been taken
  task automatic drain_results();
    s_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (beats_out != beats_in) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [CNT_W-1:0] val);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cap_reg = val;
    empty_buffer();
    @(posedge clk_i);
  endtask

  function automatic logic [KIND_W-1:0] pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 36) return OP_WRITE;
    if (r < 56) return OP_READ;
    if (r < 76) return OP_PEEK;
    if (r < 85) return OP_DISCARD;
    if (r < 93) return OP_REWIND;
    if (r < 97) return OP_CLEAR;
    return ($urandom_range(1) == 0) ? OP_SPARE6 : OP_SPARE7;
  endfunction

  function automatic logic [CNT_W-1:0] pick_count();
    int r;
    r = $urandom_range(9);
    if (r < 5) return CNT_W'($urandom_range(4));
    if (r < 8) return CNT_W'($urandom_range(40));
    if (r < 9) return CNT_W'($urandom_range(1024));
    return CNT_W'(1024);
  endfunction

  // reset capacity; empty-buffer corners, unused kinds, peek vs read, clamped discard, clear
  task automatic test_directed();
    send_op(OP_READ, 8'h00, 11'd0);
    send_op(OP_PEEK, 8'hFF, 11'd0);
    send_op(OP_DISCARD, 8'h00, 11'd0);
    send_op(OP_DISCARD, 8'h00, 11'd5);
    send_op(OP_REWIND, 8'h00, 11'd0);
    send_op(OP_CLEAR, 8'h00, 11'd0);
    send_op(OP_SPARE6, 8'hFF, 11'd1023);
    send_op(OP_SPARE7, 8'h00, 11'd1024);
    send_op(OP_WRITE, 8'h00, 11'd0);
    send_op(OP_WRITE, 8'hFF, 11'd1023);
    send_op(OP_WRITE, 8'hA5, 11'd0);
    send_op(OP_WRITE, 8'h5A, 11'd1024);
    send_op(OP_PEEK, 8'h00, 11'd0);
    send_op(OP_PEEK, 8'h00, 11'd0);
    send_op(OP_REWIND, 8'h00, 11'd0);
    send_op(OP_PEEK, 8'h00, 11'd0);
    send_op(OP_READ, 8'h00, 11'd0);
    send_op(OP_DISCARD, 8'h00, 11'd0);
    send_op(OP_DISCARD, 8'h00, 11'd1);
    send_op(OP_WRITE, 8'h3C, 11'd1023);
    send_op(OP_DISCARD, 8'h00, 11'd1024);
    send_op(OP_WRITE, 8'h81, 11'd0);
    send_op(OP_WRITE, 8'h7E, 11'd0);
    send_op(OP_CLEAR, 8'h00, 11'd0);
    send_op(OP_PEEK, 8'h00, 11'd0);
  endtask

  task automatic test_random_ops(logic [CNT_W-1:0] cap, int n_items);
    set_capacity(cap);
    for (int i = 0; i < n_items; i++) begin
      send_op(pick_kind(), BYTE_W'($urandom), pick_count());
      if ($urandom_range(149) == 0) drain_results();
    end
  endtask

  // long hold-off on the result side while operations keep coming
  task automatic test_backpressure();
    set_capacity(11'd64);
    rx_stall_left = 400;
    for (int i = 0; i < 40; i++)
      send_op((i % 3 == 2) ? OP_PEEK : OP_WRITE, BYTE_W'($urandom), pick_count());
    drain_results();
    for (int i = 0; i < 12; i++)
      send_op(OP_READ, BYTE_W'($urandom), pick_count());
  endtask

  initial begin
    foreach (store_model[i]) store_model[i] = '0;
    empty_buffer();
    tx_idle_pct = 31;
    rx_idle_pct = 87;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_ops(11'd1, 80);
    test_random_ops(11'd3, 120);
    test_random_ops(11'd0, 60);

    tx_idle_pct = 87;
    rx_idle_pct = 31;
    test_random_ops(11'd2047, 150);
    test_random_ops(11'd7, 150);
    test_random_ops(11'd16, 150);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_backpressure();
    test_random_ops(11'd1024, 200);
    test_random_ops(11'd2, 100);
    test_random_ops(11'd5, 110);

    drain_results();
    repeat (10) @(posedge clk_i);
    if (pending_results.size() != 0)
      note_error($sformatf("%0d results never arrived", pending_results.size()));
    if (err_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

[files.f]
hw/rtl/brb_pkg.sv
hw/rtl/brb_ram.sv
hw/rtl/brb_ctrl.sv
hw/rtl/brb_dp.sv
hw/rtl/byte_ring_buffer_with_peek.sv
hw/rtl/brb_checker.sv
sim/byte_ring_buffer_with_peek_test.sv
